[rtl/core/dmv_pkg.sv]
// ----------------------------------------------------------------------------
// dmv_pkg
// Shared types and constants of the dense matrix-vector multiply block.
// ----------------------------------------------------------------------------
package dmv_pkg;

  // Default sizes of the stores and the element width
  localparam int DMV_MAX_COLS  = 64;
  localparam int DMV_MAX_ROWS  = 64;
  localparam int DMV_ELEM_BITS = 16;

  // Fixed field widths on the ports
  localparam int KIND_BITS  = 2;
  localparam int POS_BITS   = 6;
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = 38;
  localparam int CFG_BITS   = 7;
  localparam int CFG_IDX_BITS = 1;

  // Configuration register indexes and reset value
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_IN_USE = 1'd1;
  localparam logic [CFG_BITS-1:0]     CFG_RESET_VAL   = 7'd64;

  // Depth of the command queue between front and back
  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic [KIND_BITS-1:0] {
    OP_MAT_WR  = 2'd0,
    OP_VEC_WR  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] cols;
    logic [CFG_BITS-1:0] rows;
  } cfg_t;

endpackage

[rtl/core/dmv_front.sv]
// ----------------------------------------------------------------------------
// dmv_front
// Accepts items, decodes the kind, drops unused kinds and out-of-range
// writes, and forms commands for the queue.
// ----------------------------------------------------------------------------
module dmv_front
  import dmv_pkg::*;
#(
  parameter int MAX_COLS  = DMV_MAX_COLS,
  parameter int MAX_ROWS  = DMV_MAX_ROWS,
  parameter int ELEM_BITS = DMV_ELEM_BITS
) (
  input  logic                         start_i,
  input  logic                         q_full_i,
  input  logic [KIND_BITS-1:0]         kind_i,
  input  logic [POS_BITS-1:0]          row_pos_i,
  input  logic [POS_BITS-1:0]          col_pos_i,
  input  logic signed [VALUE_BITS-1:0] elem_value_i,
  output logic                         push_o,
  output cmd_t                         cmd_o,
  output logic [ELEM_BITS-1:0]         value_o
);

  logic accept;
  logic row_ok;
  logic col_ok;

  assign accept = start_i && !q_full_i;
  assign row_ok = int'(row_pos_i) < MAX_ROWS;
  assign col_ok = int'(col_pos_i) < MAX_COLS;

  // Take the low element bits, or sign-extend when elements are wider
  generate
    if (ELEM_BITS <= VALUE_BITS) begin : g_trunc
      assign value_o = elem_value_i[ELEM_BITS-1:0];
    end else begin : g_sext
      assign value_o = {{(ELEM_BITS-VALUE_BITS){elem_value_i[VALUE_BITS-1]}}, elem_value_i};
    end
  endgenerate

  always_comb begin
    cmd_o.op  = op_e'(kind_i);
    cmd_o.row = row_pos_i;
    cmd_o.col = col_pos_i;
    push_o    = 1'b0;
    case (op_e'(kind_i))
      OP_MAT_WR:  push_o = accept && row_ok && col_ok;
      OP_VEC_WR:  push_o = accept && col_ok;
      OP_COMPUTE: push_o = accept;
      default:    push_o = 1'b0;  // drop the unused kind
    endcase
  end

endmodule

[rtl/core/dmv_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dmv_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dmv_cmd_fifo
  import dmv_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o    = count_q == CNT_BITS'(DEPTH);
  assign valid_o   = count_q != '0;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/core/dmv_back.sv]
// ----------------------------------------------------------------------------
// dmv_back
// Executes commands: writes the matrix and vector stores, and runs the
// row-by-row multiply-accumulate through a read, multiply, add pipeline.
// ----------------------------------------------------------------------------
module dmv_back
  import dmv_pkg::*;
#(
  parameter int MAX_COLS  = DMV_MAX_COLS,
  parameter int MAX_ROWS  = DMV_MAX_ROWS,
  parameter int ELEM_BITS = DMV_ELEM_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       cmd_valid_i,
  input  cmd_t                       cmd_i,
  input  logic [ELEM_BITS-1:0]       cmd_value_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  output logic [POS_BITS-1:0]        out_row_o,
  output logic signed [SUM_BITS-1:0] dot_sum_o,
  output logic                       last_row_o
);

  localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_BITS = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int PROD_BITS = 2 * ELEM_BITS;

  typedef struct packed {
    logic                first;
    logic                last_col;
    logic                last_row;
    logic [POS_BITS-1:0] row;
  } tag_t;

  // Stores
  logic signed [ELEM_BITS-1:0] mat_mem [MAT_DEPTH];
  logic signed [ELEM_BITS-1:0] vec_mem [MAX_COLS];

  logic                 mat_we, vec_we;
  logic [ADDR_BITS-1:0] mat_wa, mat_ra;
  logic [COL_BITS-1:0]  vec_wa;

  // Sequencer
  logic                computing_q, computing_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [COL_BITS-1:0] col_q, col_d;
  logic [COL_BITS-1:0] col_last_q, col_last_d;
  logic [ROW_BITS-1:0] row_last_q, row_last_d;
  tag_t                issue_tag;

  // Pipeline
  logic                        s1_vld_q, s2_vld_q;
  tag_t                        s1_tag_q, s2_tag_q;
  logic signed [ELEM_BITS-1:0] mat_rd_q, vec_rd_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [SUM_BITS-1:0]  prod_ext;
  logic signed [SUM_BITS-1:0]  acc_q, acc_sum;
  logic                        out_vld_q, out_vld_d;
  logic                        last_q;
  logic [POS_BITS-1:0]         out_row_q;
  logic signed [SUM_BITS-1:0]  dot_sum_q;

  assign cmd_pop_o = cmd_valid_i && !computing_q;

  assign mat_we = cmd_pop_o && (cmd_i.op == OP_MAT_WR);
  assign vec_we = cmd_pop_o && (cmd_i.op == OP_VEC_WR);
  assign mat_wa = ADDR_BITS'(cmd_i.row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(cmd_i.col);
  assign vec_wa = COL_BITS'(cmd_i.col);
  assign mat_ra = ADDR_BITS'(row_q) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(col_q);

  always_comb begin
    issue_tag.first    = col_q == '0;
    issue_tag.last_col = col_q == col_last_q;
    issue_tag.last_row = row_q == row_last_q;
    issue_tag.row      = POS_BITS'(row_q);
  end

  // Clamp the counts and turn them into last indexes
  always_comb begin
    if (cfg_i.cols == '0) begin
      col_last_d = '0;
    end else if (int'(cfg_i.cols) > MAX_COLS) begin
      col_last_d = COL_BITS'(MAX_COLS - 1);
    end else begin
      col_last_d = COL_BITS'(cfg_i.cols - 1'b1);
    end
    if (cfg_i.rows == '0) begin
      row_last_d = '0;
    end else if (int'(cfg_i.rows) > MAX_ROWS) begin
      row_last_d = ROW_BITS'(MAX_ROWS - 1);
    end else begin
      row_last_d = ROW_BITS'(cfg_i.rows - 1'b1);
    end
  end

  always_comb begin
    computing_d = computing_q;
    row_d       = row_q;
    col_d       = col_q;
    if (computing_q) begin
      if (issue_tag.last_col) begin
        col_d = '0;
        if (issue_tag.last_row) begin
          computing_d = 1'b0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (cmd_pop_o && (cmd_i.op == OP_COMPUTE)) begin
      computing_d = 1'b1;
      row_d       = '0;
      col_d       = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= signed'(cmd_value_i);
    end
    mat_rd_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= signed'(cmd_value_i);
    end
    vec_rd_q <= vec_mem[col_q];
  end

  // Fit the product to the sum width: wrap or sign-extend
  generate
    if (PROD_BITS >= SUM_BITS) begin : g_prod_wrap
      assign prod_ext = prod_q[SUM_BITS-1:0];
    end else begin : g_prod_sext
      assign prod_ext = {{(SUM_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
    end
  endgenerate

  assign acc_sum   = (s2_tag_q.first ? '0 : acc_q) + prod_ext;
  assign out_vld_d = s2_vld_q && s2_tag_q.last_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      computing_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      computing_q <= computing_d;
      row_q       <= row_d;
      col_q       <= col_d;
      s1_vld_q    <= computing_q;
      s2_vld_q    <= s1_vld_q;
      out_vld_q   <= out_vld_d;
      last_q      <= out_vld_d && s2_tag_q.last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!computing_q && cmd_pop_o && (cmd_i.op == OP_COMPUTE)) begin
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
    end
    s1_tag_q <= issue_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= mat_rd_q * vec_rd_q;
    if (s2_vld_q) begin
      acc_q <= acc_sum;
    end
    if (out_vld_d) begin
      out_row_q <= s2_tag_q.row;
      dot_sum_q <= acc_sum;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = out_row_q;
  assign dot_sum_o   = dot_sum_q;
  assign last_row_o  = last_q;

endmodule

[rtl/core/dense_matrix_vector_multiply.sv]
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// Matrix and vector element loads, then one dot product per row in use.
// A load beat is stored once the back pops it from the command queue; a
// popped compute beat gives one result per row in use, through the read,
// multiply, add pipeline.
// Throughput: one load beat per cycle while busy_o is low; a compute holds
// the queue while it issues, one multiply-accumulate per matrix element in use.
// Reset clears control and configuration (both counts 64); stores stay
// undefined until written. Results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply
  import dmv_pkg::*;
#(
  parameter int MAX_COLS  = DMV_MAX_COLS,
  parameter int MAX_ROWS  = DMV_MAX_ROWS,
  parameter int ELEM_BITS = DMV_ELEM_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [KIND_BITS-1:0]         kind_i,
  input  logic [POS_BITS-1:0]          row_pos_i,
  input  logic [POS_BITS-1:0]          col_pos_i,
  input  logic signed [VALUE_BITS-1:0] elem_value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_BITS-1:0]          cfg_wdata_i,
  output logic                         out_valid_o,
  output logic [POS_BITS-1:0]          out_row_o,
  output logic signed [SUM_BITS-1:0]   dot_sum_o,
  output logic                         last_row_o
);

  localparam int Q_WIDTH = $bits(cmd_t) + ELEM_BITS;

  cfg_t                 cfg_q;
  logic                 q_full;
  logic                 push;
  cmd_t                 front_cmd;
  logic [ELEM_BITS-1:0] front_value;
  logic [Q_WIDTH-1:0]   q_rd_data;
  logic                 q_valid;
  logic                 q_pop;
  cmd_t                 head_cmd;
  logic [ELEM_BITS-1:0] head_value;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols <= CFG_RESET_VAL;
      cfg_q.rows <= CFG_RESET_VAL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COLS_IN_USE: cfg_q.cols <= cfg_wdata_i;
        REG_ROWS_IN_USE: cfg_q.rows <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dmv_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .start_i      (start_i),
    .q_full_i     (q_full),
    .kind_i       (kind_i),
    .row_pos_i    (row_pos_i),
    .col_pos_i    (col_pos_i),
    .elem_value_i (elem_value_i),
    .push_o       (push),
    .cmd_o        (front_cmd),
    .value_o      (front_value)
  );

  dmv_cmd_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i ({front_cmd, front_value}),
    .pop_i     (q_pop),
    .rd_data_o (q_rd_data),
    .valid_o   (q_valid),
    .full_o    (q_full)
  );

  assign {head_cmd, head_value} = q_rd_data;

  dmv_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_value_i (head_value),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .dot_sum_o   (dot_sum_o),
    .last_row_o  (last_row_o)
  );

endmodule

[rtl/core/dmv_checker.sv]
// ----------------------------------------------------------------------------
// dmv_checker
// Port-level checks on result sequencing of the matrix-vector multiply.
// ----------------------------------------------------------------------------
module dmv_checker
  import dmv_pkg::*;
#(
  parameter int MAX_ROWS = DMV_MAX_ROWS
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input logic [CFG_BITS-1:0]     cfg_wdata_i,
  input logic                    out_valid_o,
  input logic [POS_BITS-1:0]     out_row_o,
  input logic                    last_row_o
);

  logic [CFG_BITS-1:0] rows_q;
  logic [POS_BITS-1:0] exp_row_q;
  logic [POS_BITS-1:0] rows_last;

  always_comb begin
    if (rows_q == '0) begin
      rows_last = '0;
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_last = POS_BITS'(MAX_ROWS - 1);
    end else begin
      rows_last = POS_BITS'(rows_q - 1'b1);
    end
  end

  // Mirror the row count and track the expected row of the next beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= CFG_RESET_VAL;
      exp_row_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_ROWS_IN_USE)) begin
        rows_q <= cfg_wdata_i;
      end
      if (out_valid_o) begin
        exp_row_q <= last_row_o ? '0 : exp_row_q + 1'b1;
      end
    end
  end

  a_last_only_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !last_row_o)
    else $error("last_row_o high without a result beat");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_row_o == exp_row_q))
    else $error("result row out of order");

  a_last_at_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (out_row_o == rows_last)))
    else $error("last_row_o does not match the configured row count");

endmodule

bind dense_matrix_vector_multiply dmv_checker #(
  .MAX_ROWS (MAX_ROWS)
) u_dmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_wdata_i (cfg_wdata_i),
  .out_valid_o (out_valid_o),
  .out_row_o   (out_row_o),
  .last_row_o  (last_row_o)
);

[tb/sv/dense_matrix_vector_multiply_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply_tb
// Loads matrix and vector elements and runs dot-product computes under
// changing row and column counts. A scoreboard mirrors both stores and
// checks every strobed row sum, row index and last-row flag in order.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply_tb;
  import dmv_pkg::*;

  localparam logic [KIND_BITS-1:0]         KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_BITS-1:0] MIN_ELEM    = 16'sh8000;
  localparam logic signed [VALUE_BITS-1:0] MAX_ELEM    = 16'sh7fff;
  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_BEATS  = 360;

  typedef struct {
    logic [POS_BITS-1:0] row;
    logic [SUM_BITS-1:0] sum;
    logic                is_last;
  } row_sum_t;

  class dot_product_board;
    logic signed [VALUE_BITS-1:0] mat [DMV_MAX_ROWS][DMV_MAX_COLS];
    logic signed [VALUE_BITS-1:0] vec [DMV_MAX_COLS];
    bit                           mat_set [DMV_MAX_ROWS][DMV_MAX_COLS];
    bit                           vec_set [DMV_MAX_COLS];
    logic [CFG_BITS-1:0]          cols_reg;
    logic [CFG_BITS-1:0]          rows_reg;
    row_sum_t                     pending_rows [$];
    int                           errors;

    function new();
      cols_reg = CFG_RESET_VAL;
      rows_reg = CFG_RESET_VAL;
      errors   = 0;
    endfunction

    function int clamp_count(logic [CFG_BITS-1:0] v, int top);
      if (v == 0) return 1;
      if (int'(v) > top) return top;
      return int'(v);
    endfunction

    function int used_cols();
      return clamp_count(cols_reg, DMV_MAX_COLS);
    endfunction

    function int used_rows();
      return clamp_count(rows_reg, DMV_MAX_ROWS);
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      if (idx == REG_COLS_IN_USE) cols_reg = data;
      else rows_reg = data;
    endfunction

    function void note_beat(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] row,
                            logic [POS_BITS-1:0] col, logic signed [VALUE_BITS-1:0] val);
      row_sum_t e;
      longint   acc;
      int       nr;
      int       nc;
      case (kind)
        OP_MAT_WR: begin
          mat[row][col]     = val;
          mat_set[row][col] = 1'b1;
        end
        OP_VEC_WR: begin
          vec[col]     = val;
          vec_set[col] = 1'b1;
        end
        OP_COMPUTE: begin
          nr = used_rows();
          nc = used_cols();
          for (int r = 0; r < nr; r++) begin
            acc = 0;
            for (int c = 0; c < nc; c++) acc += longint'(mat[r][c]) * longint'(vec[c]);
            e.row     = POS_BITS'(r);
            e.sum     = SUM_BITS'(acc);
            e.is_last = (r == nr - 1);
            pending_rows.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic [POS_BITS-1:0] row, logic [SUM_BITS-1:0] sum,
                            logic is_last);
      row_sum_t e;
      if (pending_rows.size() == 0) begin
        $error("out_row: result with none pending, actual %0d", row);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      if (row !== e.row) begin
        $error("out_row: expected %0d, actual %0d", e.row, row);
        errors++;
      end
      if (sum !== e.sum) begin
        $error("dot_sum: expected %0d, actual %0d", $signed(e.sum), $signed(sum));
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last_row: expected %0b, actual %0b", e.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [KIND_BITS-1:0]         kind_i;
  logic [POS_BITS-1:0]          row_pos_i;
  logic [POS_BITS-1:0]          col_pos_i;
  logic signed [VALUE_BITS-1:0] elem_value_i;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]      cfg_index_i;
  logic [CFG_BITS-1:0]          cfg_wdata_i;
  logic                         out_valid_o;
  logic [POS_BITS-1:0]          out_row_o;
  logic signed [SUM_BITS-1:0]   dot_sum_o;
  logic                         last_row_o;

  dot_product_board board;
  bit               gaps_on;
  int               beats_sent;

  dense_matrix_vector_multiply dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .row_pos_i    (row_pos_i),
    .col_pos_i    (col_pos_i),
    .elem_value_i (elem_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_row_o    (out_row_o),
    .dot_sum_o    (dot_sum_o),
    .last_row_o   (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) board.check_row(out_row_o, dot_sum_o, last_row_o);
  end

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0: return MIN_ELEM;
      1: return MAX_ELEM;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Leaves start high after the beat; the next caller either drives a new
  // beat or drops start at its own falling edge.
  task automatic send_beat(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] row,
                           logic [POS_BITS-1:0] col, logic signed [VALUE_BITS-1:0] val);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 32) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i       = kind;
    row_pos_i    = row;
    col_pos_i    = col;
    elem_value_i = val;
    start_i      = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_beat(kind, row, col, val);
    beats_sent++;
  endtask

  task automatic idle_until_empty();
    @(negedge clk_i);
    start_i = 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_wdata_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Write every entry the next compute reads: missing ones only, or all of them.
  task automatic fill_area(bit overwrite, bit all_min);
    int nr;
    int nc;
    nr = board.used_rows();
    nc = board.used_cols();
    for (int c = 0; c < nc; c++) begin
      if (overwrite || !board.vec_set[c])
        send_beat(OP_VEC_WR, POS_BITS'($urandom), POS_BITS'(c),
                  all_min ? MIN_ELEM : pick_value());
    end
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (overwrite || !board.mat_set[r][c])
          send_beat(OP_MAT_WR, POS_BITS'(r), POS_BITS'(c),
                    all_min ? MIN_ELEM : pick_value());
      end
    end
  endtask

  task automatic poke_region(int nr, int nc);
    if ($urandom_range(2) == 0)
      send_beat(OP_VEC_WR, POS_BITS'($urandom), POS_BITS'($urandom_range(nc - 1)),
                pick_value());
    else
      send_beat(OP_MAT_WR, POS_BITS'($urandom_range(nr - 1)),
                POS_BITS'($urandom_range(nc - 1)), pick_value());
  endtask

  task automatic send_compute();
    send_beat(OP_COMPUTE, POS_BITS'($urandom), POS_BITS'($urandom), VALUE_BITS'($urandom));
  endtask

  task automatic pick_count(output logic [CFG_BITS-1:0] v);
    case ($urandom_range(2))
      0: v = '0;
      1: v = CFG_BITS'(DMV_MAX_COLS);
      default: v = CFG_BITS'($urandom_range(65, 127));
    endcase
  endtask

  task automatic run_phase();
    logic [CFG_BITS-1:0] cols_val;
    logic [CFG_BITS-1:0] rows_val;
    int                  sel;
    int                  nr;
    int                  nc;
    sel = $urandom_range(99);
    if (sel < 70) begin
      cols_val = CFG_BITS'($urandom_range(1, 8));
      rows_val = CFG_BITS'($urandom_range(1, 8));
    end else if (sel < 80) begin
      pick_count(cols_val);
      rows_val = CFG_BITS'($urandom_range(1, 2));
    end else if (sel < 90) begin
      pick_count(rows_val);
      cols_val = CFG_BITS'($urandom_range(1, 2));
    end else begin
      cols_val = CFG_BITS'($urandom_range(9, 20));
      rows_val = CFG_BITS'($urandom_range(1, 4));
    end
    if ($urandom_range(4) != 0) begin
      if ($urandom_range(1)) begin
        write_cfg(REG_COLS_IN_USE, cols_val);
        write_cfg(REG_ROWS_IN_USE, rows_val);
      end else begin
        write_cfg(REG_ROWS_IN_USE, rows_val);
        write_cfg(REG_COLS_IN_USE, cols_val);
      end
    end
    nr = board.used_rows();
    nc = board.used_cols();
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        0: send_beat(KIND_UNUSED, POS_BITS'($urandom), POS_BITS'($urandom),
                     VALUE_BITS'($urandom));
        1: send_beat(OP_MAT_WR, POS_BITS'($urandom), POS_BITS'($urandom), pick_value());
        default: poke_region(nr, nc);
      endcase
    end
    // Now and then drop the compute and leave the loads on their own.
    if ($urandom_range(9) != 0) begin
      fill_area(1'b0, 1'b0);
      send_compute();
      // Overwrite entries while the compute is still in flight, then run again.
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 4)) poke_region(nr, nc);
        send_compute();
      end
    end
    idle_until_empty();
  endtask

  initial begin
    board        = new();
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = OP_MAT_WR;
    row_pos_i    = '0;
    col_pos_i    = '0;
    elem_value_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_COLS_IN_USE;
    cfg_wdata_i  = CFG_RESET_VAL;
    gaps_on      = 1'b1;
    beats_sent   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    write_cfg(REG_COLS_IN_USE, 7'd2);
    write_cfg(REG_ROWS_IN_USE, 7'd2);
    send_beat(OP_MAT_WR, 6'd0, 6'd0, MIN_ELEM);
    send_beat(OP_MAT_WR, 6'd0, 6'd1, MAX_ELEM);
    send_beat(OP_MAT_WR, 6'd1, 6'd0, MAX_ELEM);
    send_beat(OP_MAT_WR, 6'd1, 6'd1, MIN_ELEM);
    send_beat(OP_VEC_WR, 6'd63, 6'd0, MIN_ELEM);
    send_beat(OP_VEC_WR, 6'd0, 6'd1, MAX_ELEM);
    send_beat(KIND_UNUSED, 6'd63, 6'd63, -16'sd1);
    send_compute();
    send_beat(OP_MAT_WR, 6'd1, 6'd1, 16'sd1);
    send_beat(OP_VEC_WR, 6'd0, 6'd0, -16'sd1);
    send_compute();
    send_beat(OP_MAT_WR, 6'd63, 6'd63, 16'sd0);
    send_beat(OP_VEC_WR, 6'd0, 6'd63, -16'sd1);
    idle_until_empty();

    write_cfg(REG_COLS_IN_USE, 7'd1);
    write_cfg(REG_ROWS_IN_USE, 7'd1);
    send_compute();
    idle_until_empty();

    // Widest row with every element at the negative limit: the largest sum.
    write_cfg(REG_COLS_IN_USE, 7'd127);
    write_cfg(REG_ROWS_IN_USE, 7'd1);
    fill_area(1'b1, 1'b1);
    send_compute();
    idle_until_empty();

    write_cfg(REG_COLS_IN_USE, 7'd1);
    write_cfg(REG_ROWS_IN_USE, 7'd64);
    fill_area(1'b0, 1'b0);
    send_compute();
    idle_until_empty();

    // Zero counts saturate to one.
    write_cfg(REG_COLS_IN_USE, 7'd0);
    write_cfg(REG_ROWS_IN_USE, 7'd0);
    send_compute();
    idle_until_empty();

    for (int phase = 0; beats_sent < TARGET_BEATS; phase++) begin
      gaps_on = !(phase >= 1 && phase < 5);
      run_phase();
    end

    idle_until_empty();
    repeat (80) @(posedge clk_i);
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
